>>> sv/pngunf_pkg.sv
package pngunf_pkg;

  // filter type codes carried in the first byte of every scanline
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // configuration register indexes
  localparam logic CFG_PIXEL_BYTES = 1'b0;
  localparam logic CFG_ROW_BYTES   = 1'b1;

  localparam int CFG_DATA_W = 14;

  // bytes per pixel limits and reset values
  localparam logic [2:0]  PIX_BYTES_MIN   = 3'd3;
  localparam logic [2:0]  PIX_BYTES_MAX   = 3'd4;
  localparam logic [2:0]  PIX_BYTES_RESET = 3'd4;
  localparam logic [13:0] ROW_BYTES_RESET = 14'd8192;

  // neighbor bytes and filter type handed to the predictor
  typedef struct packed {
    logic [7:0] filter;
    logic [7:0] left;
    logic [7:0] above;
    logic [7:0] upper_left;
  } pred_in_t;

endpackage

>>> sv/pngunf_predict.sv
module pngunf_predict
  import pngunf_pkg::*;
(
  input  pred_in_t   pred_in,
  input  logic [7:0] data_byte,
  output logic [7:0] pixel_byte
);

  logic [9:0] dist_a;
  logic [9:0] dist_b;
  logic [9:0] dist_c;
  logic [9:0] sum_ab;
  logic [9:0] twice_c;
  logic [8:0] avg_sum;
  logic [7:0] paeth;
  logic [7:0] pred;

  // paeth distances without signed math: |b-c|, |a-c|, |a+b-2c|
  always_comb begin
    sum_ab  = 10'(pred_in.left) + 10'(pred_in.above);
    twice_c = 10'(pred_in.upper_left) + 10'(pred_in.upper_left);
    dist_a  = (pred_in.above >= pred_in.upper_left) ?
              10'(pred_in.above - pred_in.upper_left) :
              10'(pred_in.upper_left - pred_in.above);
    dist_b  = (pred_in.left >= pred_in.upper_left) ?
              10'(pred_in.left - pred_in.upper_left) :
              10'(pred_in.upper_left - pred_in.left);
    dist_c  = (sum_ab >= twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
    if (dist_a <= dist_b && dist_a <= dist_c) begin
      paeth = pred_in.left;
    end else if (dist_b <= dist_c) begin
      paeth = pred_in.above;
    end else begin
      paeth = pred_in.upper_left;
    end
  end

  // predictor select and reconstruction
  always_comb begin
    avg_sum = 9'(pred_in.left) + 9'(pred_in.above);
    unique case (pred_in.filter)
      FILT_SUB:   pred = pred_in.left;
      FILT_UP:    pred = pred_in.above;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    pixel_byte = data_byte + pred;
  end

endmodule

>>> sv/png_scanline_unfilter.sv
// output: a sample byte transferred at one edge shows on out_* after that edge, from the output register
// throughput: one byte per cycle while out_stall does not hold the output register; the
// prior-row memory is read one column ahead, its registered read overlapping the current
// byte, with a bypass when a one-byte row writes and reads the same entry
// reset: first byte is a filter byte of the first row, left stores zero, pixel_bytes 4,
// row_bytes 8192; the prior-row memory is not cleared, so unwritten entries read stale data
module png_scanline_unfilter
  import pngunf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_image_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pixel_byte,
  output logic                  out_row_end
);

  localparam int CW  = $clog2(MAX_ROW_BYTES);
  localparam int RBW = CW + 1;

  logic [2:0]            pixel_bytes_r;
  logic [CFG_DATA_W-1:0] row_bytes_r;

  logic [7:0]    prior_row_mem [MAX_ROW_BYTES];
  logic [7:0]    rd_data_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic [CW-1:0] rd_addr;

  logic [7:0] recent_left_r [4];
  logic [7:0] recent_upper_left_r [4];

  logic [7:0]    filter_kind_r, filter_kind_nxt;
  logic [CW-1:0] column_count_r, column_count_nxt;
  logic          expect_filter_r, expect_filter_nxt;
  logic          on_first_row_r, on_first_row_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_pixel_byte_r;
  logic          out_row_end_r;

  logic           accept;
  logic           take_filter;
  logic           produce;
  logic [2:0]     pb_eff;
  logic [1:0]     pb_idx;
  logic [RBW-1:0] rb_eff;
  logic           have_left;
  logic           last_col;
  pred_in_t       pred_in;
  logic [7:0]     result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= PIX_BYTES_RESET;
      row_bytes_r   <= ROW_BYTES_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PIXEL_BYTES: pixel_bytes_r <= cfg_data[2:0];
        CFG_ROW_BYTES:   row_bytes_r   <= cfg_data;
        default:         row_bytes_r   <= row_bytes_r;
      endcase
    end
  end

  // clamp configuration to the supported range
  always_comb begin
    if (pixel_bytes_r < PIX_BYTES_MIN) begin
      pb_eff = PIX_BYTES_MIN;
    end else if (pixel_bytes_r > PIX_BYTES_MAX) begin
      pb_eff = PIX_BYTES_MAX;
    end else begin
      pb_eff = pixel_bytes_r;
    end
    pb_idx = 2'(pb_eff - 3'd1);
    if (row_bytes_r == '0) begin
      rb_eff = RBW'(1);
    end else if (32'(row_bytes_r) > 32'(MAX_ROW_BYTES)) begin
      rb_eff = RBW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = RBW'(row_bytes_r);
    end
  end

  // handshake: the output register frees up when drained
  assign in_stall    = out_valid_r && out_stall;
  assign accept      = in_valid && !in_stall;
  assign take_filter = in_image_start || expect_filter_r;
  assign produce     = accept && !take_filter;

  // neighbor bytes
  always_comb begin
    have_left          = column_count_r >= CW'(pb_eff);
    last_col           = (RBW'(column_count_r) + RBW'(1)) >= rb_eff;
    pred_in.filter     = filter_kind_r;
    pred_in.left       = have_left ? recent_left_r[pb_idx] : 8'd0;
    pred_in.above      = on_first_row_r ? 8'd0 : (fwd_r ? fwd_data_r : rd_data_r);
    pred_in.upper_left = (have_left && !on_first_row_r) ?
                         recent_upper_left_r[pb_idx] : 8'd0;
  end

  pngunf_predict u_predict (
    .pred_in    (pred_in),
    .data_byte  (in_data_byte),
    .pixel_byte (result)
  );

  // row and column sequencing
  always_comb begin
    filter_kind_nxt   = filter_kind_r;
    column_count_nxt  = column_count_r;
    expect_filter_nxt = expect_filter_r;
    on_first_row_nxt  = on_first_row_r;
    if (accept) begin
      if (take_filter) begin
        filter_kind_nxt   = in_data_byte;
        expect_filter_nxt = 1'b0;
        if (in_image_start) begin
          column_count_nxt = '0;
          on_first_row_nxt = 1'b1;
        end
      end else if (last_col) begin
        column_count_nxt  = '0;
        expect_filter_nxt = 1'b1;
        on_first_row_nxt  = 1'b0;
      end else begin
        column_count_nxt = column_count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_kind_r   <= '0;
      column_count_r  <= '0;
      expect_filter_r <= 1'b1;
      on_first_row_r  <= 1'b1;
    end else begin
      filter_kind_r   <= filter_kind_nxt;
      column_count_r  <= column_count_nxt;
      expect_filter_r <= expect_filter_nxt;
      on_first_row_r  <= on_first_row_nxt;
    end
  end

  // left and upper-left history, newest first
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_image_start)) begin
      for (int i = 0; i < 4; i++) begin
        recent_left_r[i]       <= '0;
        recent_upper_left_r[i] <= '0;
      end
    end else if (produce) begin
      for (int i = 3; i > 0; i--) begin
        recent_left_r[i]       <= recent_left_r[i-1];
        recent_upper_left_r[i] <= recent_upper_left_r[i-1];
      end
      recent_left_r[0]       <= result;
      recent_upper_left_r[0] <= pred_in.above;
    end
  end

  // prior-row memory: write current column, read the next byte's column
  assign rd_addr = column_count_nxt;

  always_ff @(posedge clk) begin
    if (produce) begin
      prior_row_mem[column_count_r] <= result;
    end
    rd_data_r  <= prior_row_mem[rd_addr];
    fwd_data_r <= result;
  end

  // bypass when the same entry is written and read in one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= produce && (rd_addr == column_count_r);
    end
  end

  // output register
  assign out_valid_nxt = (out_valid_r && out_stall) || produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_pixel_byte_r <= result;
      out_row_end_r    <= last_col;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pixel_byte_r;
  assign out_row_end    = out_row_end_r;

  // a filter byte never yields a result
  a_filter_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && take_filter |=> !out_valid_r)
    else $error("filter byte produced a result");

  // the last byte of a row arms the next filter byte at column zero
  a_row_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    produce && last_col |=> expect_filter_r && column_count_r == '0)
    else $error("row end did not rearm filter byte");

  // a sample byte inside a row advances the column by one
  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    produce && !last_col |=> column_count_r == $past(column_count_r) + CW'(1))
    else $error("column count did not advance");

endmodule

>>> tb/png_scanline_unfilter_checker.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_checker
  import pngunf_pkg::*;
#(
  parameter int ROW_CAP = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_image_start,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_pixel_byte,
  input  logic                  out_row_end,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  // shadow of the reconstruction state
  logic [2:0]  pix_reg;
  logic [13:0] row_reg;
  logic [7:0]  prior_row [ROW_CAP];
  logic [7:0]  left_hist [4];
  logic [7:0]  above_hist [4];
  logic [7:0]  row_filter;
  int          col_pos;
  bit          want_filter;
  bit          first_row;

  // paeth predictor: neighbor closest to left + above - upper-left, ties to left then above
  function automatic logic [7:0] paeth_choice(input int a, input int b, input int c);
    int est;
    int da;
    int db;
    int dc;
    est = a + b - c;
    da = (est >= a) ? est - a : a - est;
    db = (est >= b) ? est - b : b - est;
    dc = (est >= c) ? est - c : c - est;
    if (da <= db && da <= dc) return 8'(a);
    if (db <= dc) return 8'(b);
    return 8'(c);
  endfunction

  task automatic clear_history();
    int i;
    for (i = 0; i < 4; i++) begin
      left_hist[i] = 8'd0;
      above_hist[i] = 8'd0;
    end
  endtask

  // one accepted input byte: filter byte or reconstructed sample
  task automatic reconstruct_byte(input logic [7:0] raw, input logic fresh);
    int            pb;
    int            rb;
    int            col;
    int            i;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [7:0]    guess;
    logic [7:0]    value;
    pixel_result_t item;
    if (fresh) begin
      col_pos = 0;
      want_filter = 1'b1;
      first_row = 1'b1;
      clear_history();
    end
    if (want_filter) begin
      row_filter = raw;
      want_filter = 1'b0;
      return;
    end
    pb = (pix_reg < PIX_BYTES_MIN) ? PIX_BYTES_MIN :
         (pix_reg > PIX_BYTES_MAX) ? PIX_BYTES_MAX : pix_reg;
    rb = (row_reg == 14'd0) ? 1 : row_reg;
    if (rb > ROW_CAP) rb = ROW_CAP;
    col = (col_pos >= ROW_CAP) ? ROW_CAP - 1 : col_pos;

    a = (col >= pb) ? left_hist[pb-1] : 8'd0;
    b = first_row ? 8'd0 : prior_row[col];
    c = (col >= pb && !first_row) ? above_hist[pb-1] : 8'd0;

    case (row_filter)
      FILT_SUB:   guess = a;
      FILT_UP:    guess = b;
      FILT_AVG:   guess = 8'((int'(a) + int'(b)) >> 1);
      FILT_PAETH: guess = paeth_choice(a, b, c);
      default:    guess = 8'd0;
    endcase
    value = raw + guess;

    for (i = 3; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      above_hist[i] = above_hist[i-1];
    end
    left_hist[0] = value;
    above_hist[0] = b;
    prior_row[col] = value;

    item.pixel = value;
    item.row_end = (col + 1 >= rb);
    if (item.row_end) begin
      col_pos = 0;
      want_filter = 1'b1;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    expected_pixels.push_back(item);
  endtask

  // watch both channels and the register port at every edge
  always @(posedge clk) begin
    pixel_result_t item;
    if (!rst_n) begin
      pix_reg = PIX_BYTES_RESET;
      row_reg = ROW_BYTES_RESET;
      row_filter = 8'd0;
      col_pos = 0;
      want_filter = 1'b1;
      first_row = 1'b1;
      clear_history();
      expected_pixels.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_byte %0d row_end %0d",
                 out_pixel_byte, out_row_end);
          mismatch_count++;
        end else begin
          item = expected_pixels.pop_front();
          if (out_pixel_byte !== item.pixel) begin
            $error("pixel_byte mismatch: expected %0d, got %0d", item.pixel, out_pixel_byte);
            mismatch_count++;
          end
          if (out_row_end !== item.row_end) begin
            $error("row_end mismatch: expected %0d, got %0d", item.row_end, out_row_end);
            mismatch_count++;
          end
        end
      end
      // register writes
      if (cfg_write_en) begin
        if (cfg_index == CFG_PIXEL_BYTES) pix_reg = cfg_data[2:0];
        else row_reg = cfg_data;
      end
      // input transfer
      if (in_valid && !in_stall) reconstruct_byte(in_data_byte, in_image_start);
    end
    pending_count = expected_pixels.size();
  end

endmodule

>>> tb/png_scanline_unfilter_tb.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
  import pngunf_pkg::*;

  localparam int ROW_CAP = 8192;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [7:0] FILT_UNKNOWN = 8'hFF;

  // five rows of four bytes, one per filter and one unknown filter, pixel_bytes 3
  localparam logic [7:0] WARMUP_BYTES [25] = '{
    FILT_SUB,     8'd255, 8'd1,   8'd0,   8'd255,
    FILT_UP,      8'd0,   8'd255, 8'd128, 8'd1,
    FILT_AVG,     8'd255, 8'd255, 8'd0,   8'd7,
    FILT_PAETH,   8'd0,   8'd255, 8'd200, 8'd3,
    FILT_UNKNOWN, 8'd255, 8'd0,   8'd10,  8'd20
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_write_en;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_data_byte;
  logic                  in_image_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_pixel_byte;
  logic                  out_row_end;

  int mismatch_count;
  int pending_count;
  int send_gap_pct;
  int recv_gap_pct;

  // where the stream stands within a row, to keep sequences well formed
  bit at_row_head;
  int row_col;
  int row_len;
  bit force_image;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  png_scanline_unfilter #(
    .MAX_ROW_BYTES(ROW_CAP)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end)
  );

  png_scanline_unfilter_checker #(
    .ROW_CAP(ROW_CAP)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // result side back-pressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  function automatic int effective_row_len(input logic [13:0] v);
    if (v == 14'd0) return 1;
    if (v > ROW_CAP) return ROW_CAP;
    return v;
  endfunction

  // one byte transfer, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] d, input logic s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_image_start <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (s) begin
      at_row_head = 1'b1;
      row_col = 0;
    end
    if (at_row_head) begin
      at_row_head = 1'b0;
    end else if (row_col + 1 >= row_len) begin
      row_col = 0;
      at_row_head = 1'b1;
    end else begin
      row_col++;
    end
  endtask

  // register writes once the block has drained
  task automatic write_settings(input logic [2:0] pix, input logic [13:0] rows);
    int new_len;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_PIXEL_BYTES;
    cfg_data <= CFG_DATA_W'(pix);
    @(negedge clk);
    cfg_index <= CFG_ROW_BYTES;
    cfg_data <= rows;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    // a longer row would read prior-row entries never written, so restart the image
    new_len = effective_row_len(rows);
    if (new_len > row_len) force_image = 1'b1;
    row_len = new_len;
  endtask

  function automatic logic [7:0] sample_value();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed rows, some unknown filters and broken-off rows
  task automatic run_stream(input int count);
    int k;
    logic [7:0] d;
    logic s;
    for (k = 0; k < count; k++) begin
      if (at_row_head) begin
        d = ($urandom_range(99) < 85) ? 8'($urandom_range(FILT_SUB, FILT_PAETH))
                                      : 8'($urandom_range(255));
        s = force_image || ($urandom_range(99) < 12);
      end else begin
        d = sample_value();
        s = force_image || ($urandom_range(99) < 3);
      end
      force_image = 1'b0;
      push_byte(d, s);
    end
  endtask

  // stimulus
  initial begin
    int k;
    rst_n <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_index <= CFG_PIXEL_BYTES;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data_byte <= 8'd0;
    in_image_start <= 1'b0;
    send_gap_pct = 35;
    recv_gap_pct = 68;
    at_row_head = 1'b1;
    row_col = 0;
    row_len = ROW_CAP;
    force_image = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, every filter and byte extremes
    write_settings(3'd3, 14'd4);
    for (k = 0; k < 25; k++) push_byte(WARMUP_BYTES[k], k == 0);

    // sender idles often, receiver stalls more
    run_stream(20);
    write_settings(3'd4, 14'd7);
    run_stream(40);
    write_settings(3'd0, 14'd1);
    run_stream(40);
    write_settings(3'd7, 14'd0);
    run_stream(40);
    // widest row, left part way through and then cut short by a smaller length
    write_settings(3'd3, 14'h3FFF);
    run_stream(40);
    write_settings(3'd4, 14'd9);
    run_stream(60);

    // roles swapped
    send_gap_pct = 68;
    recv_gap_pct = 35;
    write_settings(3'd3, 14'd5);
    run_stream(100);
    write_settings(3'd2, 14'd8192);
    run_stream(30);
    write_settings(3'd5, 14'd3);
    run_stream(60);
    write_settings(3'd4, 14'd2);
    run_stream(50);

    // full rate both ways
    send_gap_pct = 0;
    recv_gap_pct = 0;
    repeat (3) begin
      write_settings(3'($urandom_range(7)), 14'($urandom_range(1, 12)));
      run_stream(50);
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
